// File: src/distance_vector_table_merge_defines.svh
// ----------------------------------------------------------------------------
// Distance-vector table merge: assertion macros
// Shared concurrent assertion forms, clocked on clock, muted in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_MERGE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_MERGE_DEFINES_SVH

// same-cycle implication
`define DVTM_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dvtm assertion failed");

// next-cycle implication
`define DVTM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvtm assertion failed");

`endif

// File: src/dvtm_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector table merge package
// Field widths, result codes, register map and the search wave type.
// ----------------------------------------------------------------------------
`default_nettype none

package dvtm_pkg;

   localparam int ADDR_W     = 16;
   localparam int METRIC_W   = 16;
   localparam int OUTCOME_W  = 2;
   localparam int ENTRIES_W  = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [METRIC_W-1:0] METRIC_MAX        = 16'hFFFF;
   localparam logic [ADDR_W-1:0]   OWN_ADDRESS_RESET = 16'd8;

   localparam logic [OUTCOME_W-1:0] OUTCOME_UNCHANGED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_IMPROVED  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_ADDED     = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED   = 2'd3;

   // register index is paddr[2]
   localparam logic REG_OWN_ADDRESS = 1'b0;

   // one search wave, handed from cell to cell
   typedef struct packed {
      logic                active;
      logic                found;
      logic                improved;
      logic [ADDR_W-1:0]   dest;
      logic [ADDR_W-1:0]   sender;
      logic [METRIC_W-1:0] offered;
      logic [ADDR_W-1:0]   hop;
      logic [METRIC_W-1:0] metric;
   } link_type;

   function automatic logic [METRIC_W-1:0] bump_metric(input logic [METRIC_W-1:0] m);
      bump_metric = (m == METRIC_MAX) ? METRIC_MAX : m + METRIC_W'(1);
   endfunction

endpackage

`default_nettype wire

// File: src/dvtm_req_if.sv
// ----------------------------------------------------------------------------
// Distance-vector table merge: request channel
// Advertised entry with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvtm_req_if;
   import dvtm_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   sender;
   logic [ADDR_W-1:0]   destination;
   logic [METRIC_W-1:0] advertised_metric;

   modport source (output valid, output sender, output destination,
                   output advertised_metric, input ready);
   modport sink   (input valid, input sender, input destination,
                   input advertised_metric, output ready);
endinterface

`default_nettype wire

// File: src/dvtm_rsp_if.sv
// ----------------------------------------------------------------------------
// Distance-vector table merge: response channel
// Merge result with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvtm_rsp_if;
   import dvtm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 route_changed;
   logic [ADDR_W-1:0]    chosen_next_hop;
   logic [METRIC_W-1:0]  chosen_metric;
   logic [ENTRIES_W-1:0] entries_used;

   modport source (output valid, output outcome, output route_changed,
                   output chosen_next_hop, output chosen_metric,
                   output entries_used, input ready);
   modport sink   (input valid, input outcome, input route_changed,
                   input chosen_next_hop, input chosen_metric,
                   input entries_used, output ready);
endinterface

`default_nettype wire

// File: src/dvtm_cell.sv
// ----------------------------------------------------------------------------
// Distance-vector table merge: table cell
// Holds one route entry, matches the passing wave and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module dvtm_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               used,
   input  wire logic               append_en,
   input  wire dvtm_pkg::link_type append_data,
   input  wire dvtm_pkg::link_type link_in,
   output      dvtm_pkg::link_type link_out
);
   import dvtm_pkg::*;

   logic [ADDR_W-1:0]   dest_ff;
   logic [ADDR_W-1:0]   hop_ff;
   logic [METRIC_W-1:0] metric_ff;
   link_type            link_ff;
   link_type            link_in_next;
   logic                hit;
   logic                better;

   assign hit    = link_in.active && !link_in.found && used && (dest_ff == link_in.dest);
   assign better = link_in.offered < metric_ff;

   always_comb begin
      link_in_next = link_in;
      if (hit) begin
         link_in_next.found = 1'b1;
         if (better) begin
            link_in_next.improved = 1'b1;
            link_in_next.hop      = link_in.sender;
            link_in_next.metric   = link_in.offered;
         end else begin
            link_in_next.hop    = hop_ff;
            link_in_next.metric = metric_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
   end

   // entry storage, meaningful only below the fill count
   always_ff @(posedge clock) begin
      if (append_en) begin
         dest_ff   <= append_data.dest;
         hop_ff    <= append_data.sender;
         metric_ff <= append_data.offered;
      end else if (hit && better) begin
         hop_ff    <= link_in.sender;
         metric_ff <= link_in.offered;
      end
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

// File: src/distance_vector_table_merge.sv
// ----------------------------------------------------------------------------
// Distance-vector table merge
// Route table as a row of cells; each entry wave walks the row once.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | valid/ready         | sender, destination, advertised_metric
//  rsp     | out       | valid/ready         | outcome, route_changed, chosen_next_hop,
//          |           |                     | chosen_metric, entries_used
//  csr     | in        | psel/penable/pready | own_address at byte address 0
//
//  An item's wave passes the row cell by cell; exit_ff then captures it and
//  the done state posts the result.
//  One item is in the row at a time; req.ready is high only while idle.
//  A result waiting on rsp stalls only the final posting step.
//  Synchronous reset empties the table (fill count zero) and sets
//  own_address to 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_table_merge_defines.svh"

module distance_vector_table_merge #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dvtm_req_if.sink                               req,
   dvtm_rsp_if.source                             rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [dvtm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [dvtm_pkg::CSR_DATA_W-1:0]   pwdata,
   output      logic [dvtm_pkg::CSR_DATA_W-1:0]   prdata,
   output      logic                              pready
);
   import dvtm_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     own_address_ff;
   link_type              exit_ff, exit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]  outcome_ff, outcome_in;
   logic                  changed_ff, changed_in;
   logic [ADDR_W-1:0]     hop_ff, hop_in;
   logic [METRIC_W-1:0]   metric_ff, metric_in;
   logic [ENTRIES_W-1:0]  entries_ff, entries_in;
   logic                  append_en;
   logic                  accept;
   logic                  own_hit;
   logic                  csr_write;
   link_type              chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] active_vec;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDRESS_RESET;
      end else if (csr_write && (paddr[2] == REG_OWN_ADDRESS)) begin
         own_address_ff <= pwdata[ADDR_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_OWN_ADDRESS) ?
                   {{(CSR_DATA_W-ADDR_W){1'b0}}, own_address_ff} : '0;

   // ---------------- wave launch ----------------
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign own_hit   = (req.destination == own_address_ff);

   // own destination enters pre-resolved so no cell can match it
   always_comb begin
      chain[0] = '0;
      if (accept) begin
         chain[0].active   = 1'b1;
         chain[0].found    = own_hit;
         chain[0].improved = 1'b0;
         chain[0].dest     = req.destination;
         chain[0].sender   = req.sender;
         chain[0].offered  = bump_metric(req.advertised_metric);
         chain[0].hop      = own_hit ? own_address_ff : '0;
         chain[0].metric   = '0;
      end
   end

   // ---------------- cell row ----------------
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      dvtm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .used        (count_ff > CNT_W'(i)),
         .append_en   (append_en && (count_ff == CNT_W'(i))),
         .append_data (exit_ff),
         .link_in     (chain[i]),
         .link_out    (chain[i+1])
      );
      assign active_vec[i] = chain[i+1].active;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      exit_in      = exit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      outcome_in   = outcome_ff;
      changed_in   = changed_ff;
      hop_in       = hop_ff;
      metric_in    = metric_ff;
      append_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (chain[TABLE_DEPTH].active) begin
               exit_in  = chain[TABLE_DEPTH];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (exit_ff.found) begin
                  outcome_in = exit_ff.improved ? OUTCOME_IMPROVED : OUTCOME_UNCHANGED;
                  changed_in = exit_ff.improved;
                  hop_in     = exit_ff.hop;
                  metric_in  = exit_ff.metric;
               end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  append_en  = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  outcome_in = OUTCOME_ADDED;
                  changed_in = 1'b1;
                  hop_in     = exit_ff.sender;
                  metric_in  = exit_ff.offered;
               end else begin
                  outcome_in = OUTCOME_DROPPED;
                  changed_in = 1'b0;
                  hop_in     = '0;
                  metric_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   if (CNT_W >= ENTRIES_W) begin : g_entries_trunc
      assign entries_in = count_in[ENTRIES_W-1:0];
   end else begin : g_entries_ext
      assign entries_in = {{(ENTRIES_W-CNT_W){1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exit_ff <= exit_in;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp.ready)) begin
         outcome_ff <= outcome_in;
         changed_ff <= changed_in;
         hop_ff     <= hop_in;
         metric_ff  <= metric_in;
         entries_ff <= entries_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.outcome         = outcome_ff;
   assign rsp.route_changed   = changed_ff;
   assign rsp.chosen_next_hop = hop_ff;
   assign rsp.chosen_metric   = metric_ff;
   assign rsp.entries_used    = entries_ff;

   // ---------------- assertions ----------------
   `DVTM_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `DVTM_ASSERT_NEXT(a_append_bumps, append_en, count_ff == $past(count_ff) + CNT_W'(1))
   `DVTM_ASSERT_IMPLIES(a_single_wave, 1'b1, $onehot0(active_vec))
   `DVTM_ASSERT_IMPLIES(a_changed_code, rsp_valid_ff,
      changed_ff == (outcome_ff == OUTCOME_IMPROVED || outcome_ff == OUTCOME_ADDED))
   `DVTM_ASSERT_IMPLIES(a_wave_only_walking, active_vec != '0, state_ff == ST_WALK)

endmodule

`default_nettype wire
